/* src/rfp_pkg.sv */
package rfp_pkg;

  localparam int LEN_W   = 24;
  localparam int CNT_W   = $clog2(LEN_W + 1);
  localparam int MP_W    = 16;
  localparam int CHUNK_W = 16;
  localparam int TS_W    = 32;
  localparam int NAL_W   = 24;

  localparam logic [MP_W-1:0] MP_RESET       = 16'd1200;
  localparam logic [MP_W-1:0] MP_MIN         = 16'd3;
  localparam logic [MP_W-1:0] FU_OVERHEAD    = 16'd2;
  localparam logic [4:0]      FUA_TYPE       = 5'd28;
  localparam logic [4:0]      FIRST_BAD_TYPE = 5'd24;

  // what one accepted request means for the unit in progress
  typedef enum logic [2:0] {
    CLS_DROP,
    CLS_REJECT,
    CLS_SINGLE_HDR,
    CLS_SINGLE_DATA,
    CLS_FU_HDR,
    CLS_FU_DATA,
    CLS_FU_CHUNK
  } cls_t;

  typedef enum logic [2:0] {
    EMIT_REJECT,
    EMIT_SINGLE_HDR,
    EMIT_SINGLE_DATA,
    EMIT_IND,
    EMIT_FU_HDR,
    EMIT_FU_DATA
  } emit_t;

  typedef struct packed {
    logic  take;
    logic  div_start;
    logic  emit;
    emit_t emit_sel;
    logic  wr_frag;
    logic  wr_chunk;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* src/rfp_div.sv */
module rfp_div import rfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LEN_W-1:0] num,
  input  logic [LEN_W-1:0] den,
  output logic             done,
  output logic [LEN_W-1:0] quo_ceil
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] quo;
  logic [LEN_W-1:0] den_q;
  logic [LEN_W:0]   rem_sh;
  logic             fits;
  logic [LEN_W:0]   rem_sub;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem, quo[LEN_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign quo_ceil = quo + LEN_W'(rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(LEN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? LEN_W'(rem_sub) : LEN_W'(rem_sh);
      quo <= {quo[LEN_W-2:0], fits};
    end
  end

endmodule

/* src/rfp_datapath.sv */
module rfp_datapath import rfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [MP_W-1:0]  cfg_wr_data,
  input  logic [7:0]       data_byte,
  input  logic             first_of_nal,
  input  logic [NAL_W-1:0] nal_length,
  input  logic             frame_end,
  input  logic [TS_W-1:0]  timestamp_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             packet_start,
  output logic             packet_end,
  output logic             marker_bit,
  output logic [TS_W-1:0]  timestamp_out,
  output logic             status,
  output logic             last_of_item,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       sts
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SINGLE,
    MODE_FUA
  } mode_t;

  logic [MP_W-1:0]    max_payload;
  mode_t              unit_mode;
  logic [7:0]         saved_header;
  logic [LEN_W-1:0]   payload_left;
  logic [LEN_W-1:0]   fragments_left;
  logic [CHUNK_W-1:0] chunk_left;
  logic               first_fragment;
  logic               saved_frame_end;
  logic [TS_W-1:0]    saved_timestamp;
  logic [7:0]         byte_q;

  logic [MP_W-1:0]    mp_eff;
  logic [LEN_W-1:0]   len;
  logic               hdr_bad;
  logic               fits_single;
  logic [LEN_W-1:0]   frag_eff;
  logic               last_frag;
  logic               marker;
  logic [LEN_W-1:0]   pl_dec;
  logic [LEN_W-1:0]   pl_sat;
  logic [CHUNK_W-1:0] chunk_dec;
  logic [LEN_W-1:0]   frag_dec;
  logic [7:0]         byte_cur;
  cls_t               cls;

  logic               div_done;
  logic [LEN_W-1:0]   div_num;
  logic [LEN_W-1:0]   div_den;
  logic [LEN_W-1:0]   div_res;

  logic [7:0]         r_byte;
  logic               r_start;
  logic               r_end;
  logic               r_marker;
  logic [TS_W-1:0]    r_ts;
  logic               r_status;
  logic               r_last;

  assign mp_eff      = (max_payload < MP_MIN) ? MP_MIN : max_payload;
  assign len         = LEN_W'(nal_length);
  assign hdr_bad     = (len <= LEN_W'(1)) || data_byte[7] || (data_byte[4:0] >= FIRST_BAD_TYPE);
  assign fits_single = len <= LEN_W'(mp_eff);
  assign frag_eff    = (fragments_left == '0) ? LEN_W'(1) : fragments_left;
  assign last_frag   = frag_eff == LEN_W'(1);
  assign marker      = saved_frame_end & last_frag;
  assign pl_dec      = payload_left - 1'b1;
  assign pl_sat      = (payload_left == '0) ? '0 : pl_dec;
  assign chunk_dec   = chunk_left - 1'b1;
  assign frag_dec    = frag_eff - 1'b1;
  assign byte_cur    = cmd.take ? data_byte : byte_q;

  always_comb begin
    cls = CLS_DROP;
    if (first_of_nal) begin
      if (hdr_bad) begin
        cls = CLS_REJECT;
      end else if (fits_single) begin
        cls = CLS_SINGLE_HDR;
      end else begin
        cls = CLS_FU_HDR;
      end
    end else begin
      unique case (unit_mode)
        MODE_SINGLE: cls = CLS_SINGLE_DATA;
        MODE_FUA:    cls = (chunk_left == '0) ? CLS_FU_CHUNK : CLS_FU_DATA;
        default:     cls = CLS_DROP;
      endcase
    end
  end

  assign sts.cls      = cls;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || !out_stall;

  // fragment count on a header, chunk size at the start of each fragment
  assign div_num = (cls == CLS_FU_HDR) ? (len - 1'b1) : payload_left;
  assign div_den = (cls == CLS_FU_HDR) ? LEN_W'(mp_eff - FU_OVERHEAD) : frag_eff;

  rfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quo_ceil (div_res)
  );

  always_comb begin
    r_byte   = byte_cur;
    r_start  = 1'b0;
    r_end    = 1'b0;
    r_marker = marker;
    r_ts     = saved_timestamp;
    r_status = 1'b0;
    r_last   = 1'b0;
    unique case (cmd.emit_sel)
      EMIT_REJECT: begin
        r_byte   = '0;
        r_marker = 1'b0;
        r_ts     = timestamp_in;
        r_status = 1'b1;
        r_last   = 1'b1;
      end
      EMIT_SINGLE_HDR: begin
        r_start  = 1'b1;
        r_marker = frame_end;
        r_ts     = timestamp_in;
        r_last   = 1'b1;
      end
      EMIT_SINGLE_DATA: begin
        r_end    = pl_dec == '0;
        r_marker = saved_frame_end;
        r_last   = 1'b1;
      end
      EMIT_IND: begin
        r_byte  = {saved_header[7:5], FUA_TYPE};
        r_start = 1'b1;
      end
      EMIT_FU_HDR: begin
        r_byte = {first_fragment, last_frag, 1'b0, saved_header[4:0]};
      end
      EMIT_FU_DATA: begin
        r_end  = chunk_dec == '0;
        r_last = 1'b1;
      end
      default: begin
        r_byte = byte_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MP_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode       <= MODE_IDLE;
      saved_header    <= '0;
      payload_left    <= '0;
      fragments_left  <= '0;
      chunk_left      <= '0;
      first_fragment  <= 1'b0;
      saved_frame_end <= 1'b0;
      saved_timestamp <= '0;
    end else begin
      if (cmd.take) begin
        unique case (cls)
          CLS_REJECT: begin
            unit_mode <= MODE_IDLE;
          end
          CLS_SINGLE_HDR, CLS_FU_HDR: begin
            saved_header    <= data_byte;
            saved_frame_end <= frame_end;
            saved_timestamp <= timestamp_in;
            payload_left    <= len - 1'b1;
            chunk_left      <= '0;
            if (cls == CLS_SINGLE_HDR) begin
              unit_mode      <= MODE_SINGLE;
              fragments_left <= '0;
              first_fragment <= 1'b0;
            end else begin
              unit_mode      <= MODE_FUA;
              first_fragment <= 1'b1;
            end
          end
          CLS_FU_CHUNK: begin
            fragments_left <= frag_eff;
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        unique case (cmd.emit_sel)
          EMIT_SINGLE_DATA: begin
            payload_left <= pl_dec;
            if (pl_dec == '0) begin
              unit_mode <= MODE_IDLE;
            end
          end
          EMIT_FU_HDR: begin
            first_fragment <= 1'b0;
          end
          EMIT_FU_DATA: begin
            chunk_left   <= chunk_dec;
            payload_left <= pl_sat;
            if (chunk_dec == '0) begin
              fragments_left <= (pl_sat == '0) ? '0 : frag_dec;
              if (frag_dec == '0 || pl_sat == '0) begin
                unit_mode <= MODE_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.wr_frag) begin
        fragments_left <= div_res;
      end
      if (cmd.wr_chunk) begin
        // chunk never exceeds the fragment payload size, so it fits
        chunk_left <= (div_res == '0) ? CHUNK_W'(1) : CHUNK_W'(div_res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte      <= r_byte;
      packet_start  <= r_start;
      packet_end    <= r_end;
      marker_bit    <= r_marker;
      timestamp_out <= r_ts;
      status        <= r_status;
      last_of_item  <= r_last;
    end
  end

endmodule

/* src/rfp_ctrl.sv */
module rfp_ctrl import rfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IN        = 6'b000001,
    S_DIV_FRAG  = 6'b000010,
    S_DIV_CHUNK = 6'b000100,
    S_IND       = 6'b001000,
    S_FU_HDR    = 6'b010000,
    S_DATA      = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign take     = (state == S_IN) && in_valid && sts.out_free;
  assign in_stall = !((state == S_IN) && sts.out_free);

  always_comb begin
    state_next    = state;
    cmd.take      = take;
    cmd.div_start = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_sel  = EMIT_FU_DATA;
    cmd.wr_frag   = 1'b0;
    cmd.wr_chunk  = 1'b0;
    unique case (state)
      S_IN: begin
        if (take) begin
          unique case (sts.cls)
            CLS_REJECT: begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_REJECT;
            end
            CLS_SINGLE_HDR: begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_SINGLE_HDR;
            end
            CLS_SINGLE_DATA: begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_SINGLE_DATA;
            end
            CLS_FU_DATA: begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_FU_DATA;
            end
            CLS_FU_HDR: begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_FRAG;
            end
            CLS_FU_CHUNK: begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_CHUNK;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV_FRAG: begin
        if (sts.div_done) begin
          cmd.wr_frag = 1'b1;
          state_next  = S_IN;
        end
      end
      S_DIV_CHUNK: begin
        if (sts.div_done) begin
          cmd.wr_chunk = 1'b1;
          state_next   = S_IND;
        end
      end
      S_IND: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_IND;
          state_next   = S_FU_HDR;
        end
      end
      S_FU_HDR: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_FU_HDR;
          state_next   = S_DATA;
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_FU_DATA;
          state_next   = S_IN;
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  // a division result only shows up while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV_FRAG || state == S_DIV_CHUNK))
    else $error("divider finished outside a divide state");

  a_start_waits: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIV_FRAG || state == S_DIV_CHUNK))
    else $error("divider started but sequencer not waiting");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten while held");

  a_chunk_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_IND && cmd.emit) |=> (state == S_FU_HDR) ##1 (state == S_FU_HDR || state == S_DATA))
    else $error("fu-a header sequence broken");

endmodule

/* src/h264_rtp_fua_packetizer.sv */
// h264 rtp packetizer, single nal unit and fu-a modes.
// input channel: one nal byte per request (in_valid / in_stall); the header
//   byte carries first_of_nal, nal_length, frame_end and timestamp_in.
// output channel: one payload byte or reject status per request
//   (out_valid / out_stall), with packet_start / packet_end framing.
// config: cfg_wr_en / cfg_wr_data writes max_payload; the user must write it
//   only while the block is idle, the block itself does not enforce it.
// throughput: while the receiver does not stall, a byte that gives a single
//   result (single-packet bytes, fu-a bytes inside a fragment, rejected
//   headers) is taken every cycle and shows on the output in the cycle after
//   it is accepted.
// a fu-a header byte holds the input while the serial divider works out the
//   fragment count; the first byte of every fragment holds it while the same
//   divider works out the chunk size, then indicator, fu header and data byte
//   leave in that order. dropped bytes (no unit open) give nothing.
// reset (rst, synchronous) empties the output register, closes any open
//   unit and loads max_payload with 1200.
// when the receiver stalls, the result stays in the output register and
//   in_stall rises until it is taken; nothing is lost.
module h264_rtp_fua_packetizer import rfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [MP_W-1:0]  cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             first_of_nal,
  input  logic [NAL_W-1:0] nal_length,
  input  logic             frame_end,
  input  logic [TS_W-1:0]  timestamp_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             packet_start,
  output logic             packet_end,
  output logic             marker_bit,
  output logic [TS_W-1:0]  timestamp_out,
  output logic             status,
  output logic             last_of_item
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  rfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .data_byte     (data_byte),
    .first_of_nal  (first_of_nal),
    .nal_length    (nal_length),
    .frame_end     (frame_end),
    .timestamp_in  (timestamp_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .packet_start  (packet_start),
    .packet_end    (packet_end),
    .marker_bit    (marker_bit),
    .timestamp_out (timestamp_out),
    .status        (status),
    .last_of_item  (last_of_item),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* tb/tb_h264_rtp_fua_packetizer.sv */
import rfp_pkg::*;

typedef enum logic [1:0] {UNIT_IDLE, UNIT_SINGLE, UNIT_FUA} unit_mode_e;

typedef struct packed {
  logic [7:0]      data;
  logic            start;
  logic            pkt_end;
  logic            marker;
  logic [TS_W-1:0] ts;
  logic            stat;
  logic            last;
} pay_result_t;

class fua_scoreboard;
  logic [MP_W-1:0]    max_payload;
  unit_mode_e         mode;
  logic [7:0]         hdr;
  logic [LEN_W-1:0]   payload_left;
  logic [LEN_W-1:0]   frags_left;
  logic [CHUNK_W-1:0] chunk_left;
  logic               first_frag;
  logic               fend;
  logic [TS_W-1:0]    ts;
  pay_result_t        pending[$];
  int                 errors;
  int                 matched;
  int                 rejects;
  int                 fragments;
  int                 singles;

  function new();
    max_payload  = MP_RESET;
    mode         = UNIT_IDLE;
    hdr          = '0;
    payload_left = '0;
    frags_left   = '0;
    chunk_left   = '0;
    first_frag   = 1'b0;
    fend         = 1'b0;
    ts           = '0;
    errors       = 0;
    matched      = 0;
    rejects      = 0;
    fragments    = 0;
    singles      = 0;
  endfunction

  function void set_max_payload(logic [MP_W-1:0] v);
    max_payload = v;
  endfunction

  function logic [31:0] ceil_div(logic [31:0] num, logic [31:0] den);
    if (den == '0) den = 32'd1;
    return num / den + (((num % den) != '0) ? 32'd1 : 32'd0);
  endfunction

  function pay_result_t mk(logic [7:0] d, logic s, logic e, logic m, logic [TS_W-1:0] t,
                           logic st);
    pay_result_t r;
    r.data    = d;
    r.start   = s;
    r.pkt_end = e;
    r.marker  = m;
    r.ts      = t;
    r.stat    = st;
    r.last    = 1'b0;
    return r;
  endfunction

  // works out what one accepted request must produce
  function void note_request(logic [7:0] b, logic first, logic [NAL_W-1:0] len, logic fe,
                             logic [TS_W-1:0] tsi);
    pay_result_t      res [3];
    int               k;
    logic [LEN_W-1:0] ln;
    logic [31:0]      mp;
    logic [31:0]      chunk;
    logic             last_frag;
    logic             mark;
    k  = 0;
    ln = LEN_W'(len);
    mp = (max_payload < MP_MIN) ? 32'(MP_MIN) : 32'(max_payload);
    if (first) begin
      if (ln <= LEN_W'(1) || b[7] || b[4:0] >= FIRST_BAD_TYPE) begin
        mode   = UNIT_IDLE;
        res[k] = mk(8'h00, 1'b0, 1'b0, 1'b0, tsi, 1'b1);
        k++;
        rejects++;
      end else begin
        hdr          = b;
        fend         = fe;
        ts           = tsi;
        payload_left = ln - 1'b1;
        chunk_left   = '0;
        if (32'(ln) <= mp) begin
          mode       = UNIT_SINGLE;
          frags_left = '0;
          first_frag = 1'b0;
          res[k]     = mk(b, 1'b1, 1'b0, fe, tsi, 1'b0);
          k++;
          singles++;
        end else begin
          mode       = UNIT_FUA;
          frags_left = LEN_W'(ceil_div(32'(payload_left), mp - 32'(FU_OVERHEAD)));
          first_frag = 1'b1;
        end
      end
    end else if (mode == UNIT_SINGLE) begin
      payload_left = payload_left - 1'b1;
      res[k] = mk(b, 1'b0, payload_left == '0, fend, ts, 1'b0);
      k++;
      if (payload_left == '0) mode = UNIT_IDLE;
    end else if (mode == UNIT_FUA) begin
      if (frags_left == '0) frags_left = LEN_W'(1);
      last_frag = (frags_left == LEN_W'(1));
      mark      = fend & last_frag;
      if (chunk_left == '0) begin
        chunk = ceil_div(32'(payload_left), 32'(frags_left));
        if (chunk == '0) chunk = 32'd1;
        chunk_left = CHUNK_W'(chunk);
        res[k] = mk({hdr[7:5], FUA_TYPE}, 1'b1, 1'b0, mark, ts, 1'b0);
        k++;
        res[k] = mk({first_frag, last_frag, 1'b0, hdr[4:0]}, 1'b0, 1'b0, mark, ts, 1'b0);
        k++;
        first_frag = 1'b0;
        fragments++;
      end
      chunk_left = chunk_left - 1'b1;
      if (payload_left != '0) payload_left = payload_left - 1'b1;
      res[k] = mk(b, 1'b0, chunk_left == '0, mark, ts, 1'b0);
      k++;
      if (chunk_left == '0) begin
        frags_left = frags_left - 1'b1;
        if (frags_left == '0 || payload_left == '0) begin
          mode       = UNIT_IDLE;
          frags_left = '0;
        end
      end
    end
    if (k > 0) res[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) pending.push_back(res[i]);
  endfunction

  function void cmp(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endfunction

  function void check_result(pay_result_t got);
    pay_result_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none got byte %0h status %0b",
               $time, got.data, got.stat);
      return;
    end
    want = pending.pop_front();
    cmp("out_byte", want.data, got.data);
    cmp("packet_start", want.start, got.start);
    cmp("packet_end", want.pkt_end, got.pkt_end);
    cmp("marker_bit", want.marker, got.marker);
    cmp("timestamp_out", want.ts, got.ts);
    cmp("status", want.stat, got.stat);
    cmp("last_of_item", want.last, got.last);
    matched++;
  endfunction
endclass

module tb_h264_rtp_fua_packetizer;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 55;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [MP_W-1:0]  cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       data_byte;
  logic             first_of_nal;
  logic [NAL_W-1:0] nal_length;
  logic             frame_end;
  logic [TS_W-1:0]  timestamp_in;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             packet_start;
  logic             packet_end;
  logic             marker_bit;
  logic [TS_W-1:0]  timestamp_out;
  logic             status;
  logic             last_of_item;

  fua_scoreboard sb = new();
  pay_result_t   seen;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_request;
  int            hold_count;
  int            items_sent;
  int            settings_used;
  int            quiet_cycles;

  h264_rtp_fua_packetizer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .first_of_nal  (first_of_nal),
    .nal_length    (nal_length),
    .frame_end     (frame_end),
    .timestamp_in  (timestamp_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .packet_start  (packet_start),
    .packet_end    (packet_end),
    .marker_bit    (marker_bit),
    .timestamp_out (timestamp_out),
    .status        (status),
    .last_of_item  (last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold when one is requested
  initial begin
    out_stall  <= 1'b0;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_count   = hold_request;
        hold_request = 0;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        sb.note_request(data_byte, first_of_nal, nal_length, frame_end, timestamp_in);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        seen.data    = out_byte;
        seen.start   = packet_start;
        seen.pkt_end = packet_end;
        seen.marker  = marker_bit;
        seen.ts      = timestamp_out;
        seen.stat    = status;
        seen.last    = last_of_item;
        sb.check_result(seen);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results still pending",
                 $time, quiet_cycles, sb.pending.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [NAL_W-1:0] len,
                           input logic fe, input logic [TS_W-1:0] tsi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    first_of_nal <= first;
    nal_length   <= len;
    frame_end    <= fe;
    timestamp_in <= tsi;
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // body bytes; unit fields carry noise since they are only read on the header
  task automatic send_body(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), 1'b0, NAL_W'($urandom), 1'($urandom), TS_W'($urandom));
    end
  endtask

  task automatic write_max_payload(input logic [MP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_max_payload(v);
    settings_used++;
  endtask

  // let every pending result out, then give a header division time to finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_unit(input int mp_eff);
    int         pick;
    int         len;
    int         body;
    int         top;
    logic [7:0] hdr;
    pick = $urandom_range(99);
    hdr  = 8'($urandom);
    if (pick < 6) begin
      send_body(1);
    end else if (pick < 18) begin
      case ($urandom_range(2))
        0: hdr[7] = 1'b1;
        1: hdr[4:0] = 5'($urandom_range(31, 24));
        default: hdr[7] = 1'b0;
      endcase
      if (hdr[7] || hdr[4:0] >= FIRST_BAD_TYPE) len = $urandom & 'hFF_FFFF;
      else len = $urandom_range(1, 0);
      send_byte(hdr, 1'b1, NAL_W'(len), 1'($urandom), TS_W'($urandom));
    end else begin
      hdr[7]   = 1'b0;
      hdr[4:0] = 5'($urandom_range(23, 0));
      top = (mp_eff * 3 < 30) ? mp_eff * 3 : 30;
      if (pick < 24) len = $urandom & 'hFF_FFFF;
      else if (pick < 50 || top <= mp_eff) len = $urandom_range(2, (mp_eff < 30) ? mp_eff : 30);
      else len = $urandom_range(mp_eff + 1, top);
      body = (len > 0) ? len - 1 : 0;
      // long units are cut short, and some short ones too
      if (body > 40) body = $urandom_range(40, 1);
      else if ($urandom_range(9) == 0) body = $urandom_range(body, 0);
      send_byte(hdr, 1'b1, NAL_W'(len), 1'($urandom), TS_W'($urandom));
      send_body(body);
    end
  endtask

  task automatic run_phase(input logic [MP_W-1:0] mp, input int idle, input int stall,
                           input int hold);
    int first_item;
    int mp_eff;
    drain();
    write_max_payload(mp);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    hold_request   = hold;
    mp_eff     = (mp < MP_MIN) ? MP_MIN : mp;
    first_item = items_sent;
    while (items_sent - first_item < PHASE_ITEMS) send_unit(mp_eff);
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    data_byte      <= '0;
    first_of_nal   <= 1'b0;
    nal_length     <= '0;
    frame_end      <= 1'b0;
    timestamp_in   <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    items_sent     = 0;
    settings_used  = 0;
    quiet_cycles   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rejects, exact-fit single unit, uneven fu-a split, stray byte,
    // unit abandoned by a new header
    write_max_payload(16'd6);
    send_byte(8'h65, 1'b1, 24'd0, 1'b0, 32'h0000_0000);
    send_byte(8'h41, 1'b1, 24'd1, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h85, 1'b1, 24'd5, 1'b0, 32'h1234_5678);
    send_byte(8'h18, 1'b1, 24'd5, 1'b1, 32'h0000_0001);
    send_byte(8'h7F, 1'b1, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h77, 1'b1, 24'd6, 1'b0, 32'hFFFF_FFFF);
    send_body(5);
    send_byte(8'h65, 1'b1, 24'd8, 1'b1, 32'h0000_0000);
    send_body(7);
    send_body(1);
    send_byte(8'h05, 1'b1, 24'hFF_FFFF, 1'b1, 32'h8000_0000);
    send_body(2);
    send_byte(8'h00, 1'b1, 24'd2, 1'b1, 32'h7FFF_FFFF);
    send_body(1);

    run_phase(16'd0, 0, 0, 0);
    run_phase(16'd3, 72, 0, 0);
    run_phase(16'd16, 0, 72, 300);
    run_phase(16'd7, 13, 13, 0);
    run_phase(16'd65535, 0, 0, 0);
    run_phase(16'd1200, 72, 0, 0);
    run_phase(16'd4, 0, 72, 0);
    run_phase(MP_W'($urandom_range(40, 3)), 13, 13, 0);
    drain();

    $display("sent %0d requests over %0d max_payload settings; %0d results checked",
             items_sent, settings_used, sb.matched);
    $display("single units %0d, fu-a fragments %0d, rejected units %0d, %0d mismatches",
             sb.singles, sb.fragments, sb.rejects, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
